[rtl/lppd_pkg.sv]
// shared types and constants for the length-prefixed packet deframer
// no dependencies; used by length_prefixed_packet_deframer
package lppd_pkg;

    // deframer phase
    typedef enum logic [2:0] {
        PH_HDR_HI  = 3'd0,
        PH_HDR_LO  = 3'd1,
        PH_SIZE    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_ERROR   = 3'd4
    } phase_t;

    // result kind codes
    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    localparam int ID_W   = 14;
    localparam int SIZE_W = 24;
    localparam int BYTE_W = 8;
    localparam int TDATA_W = 48;

    // one result word
    typedef struct packed {
        kind_t               kind;
        logic [ID_W-1:0]     packet_id;
        logic [SIZE_W-1:0]   payload_size;
        logic [BYTE_W-1:0]   payload_byte;
        logic                last_of_packet;
    } result_t;

endpackage

[rtl/length_prefixed_packet_deframer.sv]
// length-prefixed packet deframer, registered output; 1 byte per cycle while
// s_tready is high; high header and non-final size bytes only update state registers
// an output register plus one skid register keep s_tready free of m_tready
// aresetn (synchronous, active low) returns to waiting for a header, clears
// the sticky error state and drops both result registers
// depends on lppd_pkg
module length_prefixed_packet_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [13:0] packet_id, [37:14] payload_size,
                                   // [45:38] payload_byte, [47:46] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last_of_packet
);

    lppd_pkg::phase_t                    phase_reg, phase_next;
    logic [7:0]                          header_high_reg, header_high_next;
    logic [lppd_pkg::ID_W-1:0]           current_id_reg, current_id_next;
    logic [1:0]                          size_left_reg, size_left_next;
    logic [lppd_pkg::SIZE_W-1:0]         size_accum_reg, size_accum_next;
    logic [lppd_pkg::SIZE_W-1:0]         payload_left_reg, payload_left_next;

    lppd_pkg::result_t                   res;
    logic                                res_valid;
    logic                                accept;

    lppd_pkg::result_t                   out_reg, skid_reg;
    logic                                out_valid_reg, skid_valid_reg;

    logic [lppd_pkg::ID_W-1:0]           id_in;
    logic [lppd_pkg::SIZE_W-1:0]         accum_in;
    logic [1:0]                          left_dec;
    logic [lppd_pkg::SIZE_W-1:0]         payload_dec;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign id_in       = {header_high_reg, s_tdata[7:2]};
    assign accum_in    = {size_accum_reg[lppd_pkg::SIZE_W-9:0], s_tdata};
    assign left_dec    = size_left_reg - 2'd1;
    assign payload_dec = payload_left_reg - lppd_pkg::SIZE_W'(1);

    // next state and result for the accepted byte
    always_comb begin
        phase_next        = phase_reg;
        header_high_next  = header_high_reg;
        current_id_next   = current_id_reg;
        size_left_next    = size_left_reg;
        size_accum_next   = size_accum_reg;
        payload_left_next = payload_left_reg;
        res_valid         = 1'b0;
        res               = '0;
        res.kind          = lppd_pkg::KIND_START;
        if (accept) begin
            unique case (phase_reg)
                lppd_pkg::PH_HDR_LO: begin
                    current_id_next = id_in;
                    if (id_in == '0) begin
                        res_valid  = 1'b1;
                        res.kind   = lppd_pkg::KIND_ERROR;
                        phase_next = lppd_pkg::PH_ERROR;
                    end else begin
                        size_left_next  = s_tdata[1:0];
                        size_accum_next = '0;
                        if (s_tdata[1:0] == 2'd0) begin
                            // no size bytes: zero-length packet
                            res_valid          = 1'b1;
                            res.packet_id      = id_in;
                            res.last_of_packet = 1'b1;
                            phase_next         = lppd_pkg::PH_HDR_HI;
                        end else begin
                            phase_next = lppd_pkg::PH_SIZE;
                        end
                    end
                end
                lppd_pkg::PH_SIZE: begin
                    size_accum_next = accum_in;
                    size_left_next  = left_dec;
                    if (left_dec == 2'd0) begin
                        res_valid     = 1'b1;
                        res.packet_id = current_id_reg;
                        if (accum_in == '0) begin
                            res.last_of_packet = 1'b1;
                            phase_next         = lppd_pkg::PH_HDR_HI;
                        end else begin
                            res.payload_size  = accum_in;
                            payload_left_next = accum_in;
                            phase_next        = lppd_pkg::PH_PAYLOAD;
                        end
                    end
                end
                lppd_pkg::PH_PAYLOAD: begin
                    payload_left_next = payload_dec;
                    res_valid         = 1'b1;
                    res.kind          = lppd_pkg::KIND_DATA;
                    res.packet_id     = current_id_reg;
                    res.payload_size  = size_accum_reg;
                    res.payload_byte  = s_tdata;
                    if (payload_dec == '0) begin
                        res.last_of_packet = 1'b1;
                        phase_next         = lppd_pkg::PH_HDR_HI;
                    end
                end
                lppd_pkg::PH_ERROR: begin
                    // sticky until reset
                    phase_next = lppd_pkg::PH_ERROR;
                end
                default: begin
                    header_high_next = s_tdata;
                    phase_next       = lppd_pkg::PH_HDR_LO;
                end
            endcase
        end
    end

    // deframer state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= lppd_pkg::PH_HDR_HI;
            header_high_reg  <= '0;
            current_id_reg   <= '0;
            size_left_reg    <= '0;
            size_accum_reg   <= '0;
            payload_left_reg <= '0;
        end else begin
            phase_reg        <= phase_next;
            header_high_reg  <= header_high_next;
            current_id_reg   <= current_id_next;
            size_left_reg    <= size_left_next;
            size_accum_reg   <= size_accum_next;
            payload_left_reg <= payload_left_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_reg       <= res;
                out_valid_reg <= res_valid;
            end
        end else if (res_valid) begin
            skid_reg       <= res;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.payload_byte, out_reg.payload_size, out_reg.packet_id};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last_of_packet;

endmodule
